// ===== src/pvp_pkg.sv =====
// Package for the perspective vertex projection block.
// Holds field widths, register indexes, sideband type and helper functions.
// No dependencies.
`default_nettype none

package pvp_pkg;

    // Field and datapath widths
    localparam int COORD_W  = 32;
    localparam int NUM_W    = 48;   // |clip value| * 2^16
    localparam int DEN_W    = 32;   // |w|
    localparam int ADDR_W   = 5;
    localparam int PIX_W    = 9;
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 56;

    localparam logic [NUM_W-1:0] Q_ONE_MAG = NUM_W'(65536);

    // Register indexes, word addressed on paddr[4:2]
    typedef enum logic [2:0] {
        REG_SCALE_X      = 3'd0,
        REG_SCALE_Y      = 3'd1,
        REG_OFFSET_X     = 3'd2,
        REG_OFFSET_Y     = 3'd3,
        REG_DEPTH_SCALE  = 3'd4,
        REG_DEPTH_OFFSET = 3'd5,
        REG_CLIP_X_LIMIT = 3'd6
    } cfg_reg_t;

    // Control bits that ride alongside the divider stages
    typedef struct packed {
        logic valid;
        logic w_zero;
        logic neg_x;
        logic neg_y;
        logic neg_z;
    } div_side_t;

    // Saturate a 49 bit signed sum to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic signed [48:0] hi;
        logic signed [48:0] lo;
        hi = 49'sh0_0000_7FFF_FFFF;
        lo = -49'sh0_0000_8000_0000;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Magnitude of a 32 bit signed value as unsigned
    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        if (v[31]) begin
            return 32'd0 - v;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/pvp_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on pvp_pkg for the operand widths.
`default_nettype none

module pvp_div (
    input  wire logic                    aclk,
    input  wire logic                    en,
    input  wire logic [pvp_pkg::NUM_W-1:0] num_in,
    input  wire logic [pvp_pkg::DEN_W-1:0] den_in,
    output logic      [pvp_pkg::NUM_W-1:0] quo_out
);
    import pvp_pkg::*;

    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [NUM_W-1:0] quo_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    logic [DEN_W-1:0] rem_reg [NUM_W];

    logic [NUM_W-1:0] num_src  [NUM_W];
    logic [NUM_W-1:0] quo_src  [NUM_W];
    logic [DEN_W-1:0] den_src  [NUM_W];
    logic [DEN_W-1:0] rem_src  [NUM_W];
    logic [DEN_W:0]   trial    [NUM_W];
    logic [NUM_W-1:0] num_next [NUM_W];
    logic [NUM_W-1:0] quo_next [NUM_W];
    logic [DEN_W-1:0] rem_next [NUM_W];

    // Each stage shifts in one numerator bit and tries one subtract
    always_comb begin
        for (int i = 0; i < NUM_W; i++) begin
            if (i == 0) begin
                num_src[i] = num_in;
                den_src[i] = den_in;
                rem_src[i] = '0;
                quo_src[i] = '0;
            end else begin
                num_src[i] = num_reg[i-1];
                den_src[i] = den_reg[i-1];
                rem_src[i] = rem_reg[i-1];
                quo_src[i] = quo_reg[i-1];
            end
            trial[i]    = {rem_src[i], num_src[i][NUM_W-1]};
            num_next[i] = {num_src[i][NUM_W-2:0], 1'b0};
            if (trial[i] >= {1'b0, den_src[i]}) begin
                rem_next[i] = DEN_W'(trial[i] - {1'b0, den_src[i]});
                quo_next[i] = {quo_src[i][NUM_W-2:0], 1'b1};
            end else begin
                rem_next[i] = trial[i][DEN_W-1:0];
                quo_next[i] = {quo_src[i][NUM_W-2:0], 1'b0};
            end
        end
    end

    // Advance all stages together
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_W; i++) begin
                num_reg[i] <= num_next[i];
                den_reg[i] <= den_src[i];
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
            end
        end
    end

    assign quo_out = quo_reg[NUM_W-1];

endmodule

`default_nettype wire

// ===== src/perspective_vertex_projection.sv =====
// Perspective vertex projection: camera-space point in, raster pixel out.
// Depends on pvp_pkg and pvp_div.
//
// Usage:
//   Write the frustum terms over the APB port (word i at byte address 4*i)
//   while no item is in flight. Send one point per item on the s_axis
//   channel: tdata holds pos_x, pos_y, pos_z. Each item gives exactly one
//   result on m_axis: tdata holds pixel_x, pixel_y, ndc_depth and tuser
//   holds the visible flag.
// Pipeline: one multiply stage loaded at the accepting edge, one
//   add/saturate stage, 48 divider stages and one output stage lead to
//   m_axis_tvalid. The divider retires one quotient bit per stage.
// Throughput: one item per cycle when the output is not stalled; every
//   stage is registered and a new item may enter each such cycle.
// Stall: when the output holds an item that is not taken, the whole
//   pipeline holds and s_axis_tready drops; nothing is lost or repeated.
// Reset (aresetn low, synchronous): registers return to their defaults
//   and all items in flight are dropped.
// A point with w of zero comes out not visible with zero fields.
`default_nettype none

module perspective_vertex_projection #(
    parameter int IMAGE_WIDTH  = 512,
    parameter int IMAGE_HEIGHT = 512
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [pvp_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    // points in
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z
    input  wire logic [pvp_pkg::S_DATA_W-1:0] s_axis_tdata,
    // results out
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // [8:0] pixel_x, [17:9] pixel_y, [49:18] ndc_depth, [55:50] zero
    output logic      [pvp_pkg::M_DATA_W-1:0] m_axis_tdata,
    // [0] visible
    output logic      [0:0]                   m_axis_tuser
);
    import pvp_pkg::*;

    localparam int XW = $clog2(IMAGE_WIDTH);
    localparam int YW = $clog2(IMAGE_HEIGHT);
    localparam logic [XW:0] SIZE_X = (XW+1)'(IMAGE_WIDTH);
    localparam logic [YW:0] SIZE_Y = (YW+1)'(IMAGE_HEIGHT);

    // ---------------- configuration registers ----------------
    logic signed [31:0] scale_x_reg, scale_y_reg, offset_x_reg, offset_y_reg;
    logic signed [31:0] depth_scale_reg, depth_offset_reg;
    logic        [30:0] clip_x_limit_reg;
    logic               cfg_wr;
    cfg_reg_t           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = cfg_reg_t'(paddr[4:2]);

    // Write one register; unknown indexes drop the write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_x_reg      <= 32'sd65536;
            scale_y_reg      <= 32'sd65536;
            offset_x_reg     <= 32'sd0;
            offset_y_reg     <= 32'sd0;
            depth_scale_reg  <= -32'sd65667;
            depth_offset_reg <= -32'sd13120;
            clip_x_limit_reg <= 31'd65536;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SCALE_X:      scale_x_reg      <= pwdata;
                REG_SCALE_Y:      scale_y_reg      <= pwdata;
                REG_OFFSET_X:     offset_x_reg     <= pwdata;
                REG_OFFSET_Y:     offset_y_reg     <= pwdata;
                REG_DEPTH_SCALE:  depth_scale_reg  <= pwdata;
                REG_DEPTH_OFFSET: depth_offset_reg <= pwdata;
                REG_CLIP_X_LIMIT: clip_x_limit_reg <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (cfg_idx)
            REG_SCALE_X:      prdata = scale_x_reg;
            REG_SCALE_Y:      prdata = scale_y_reg;
            REG_OFFSET_X:     prdata = offset_x_reg;
            REG_OFFSET_Y:     prdata = offset_y_reg;
            REG_DEPTH_SCALE:  prdata = depth_scale_reg;
            REG_DEPTH_OFFSET: prdata = depth_offset_reg;
            REG_CLIP_X_LIMIT: prdata = {1'b0, clip_x_limit_reg};
            default:          prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic en;
    logic out_valid_reg;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    // ---------------- stage 1: products ----------------
    logic signed [31:0] in_x, in_y, in_z;
    logic               s1_valid_reg;
    logic signed [63:0] p_xs_reg, p_zox_reg, p_ys_reg, p_zoy_reg, p_zd_reg;
    logic signed [31:0] s1_z_reg;

    assign in_x = s_axis_tdata[31:0];
    assign in_y = s_axis_tdata[63:32];
    assign in_z = s_axis_tdata[95:64];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_xs_reg  <= in_x * scale_x_reg;
            p_zox_reg <= in_z * offset_x_reg;
            p_ys_reg  <= in_y * scale_y_reg;
            p_zoy_reg <= in_z * offset_y_reg;
            p_zd_reg  <= in_z * depth_scale_reg;
            s1_z_reg  <= in_z;
        end
    end

    // ---------------- stage 2: floor, sum, saturate, magnitudes ----------------
    logic signed [31:0] clip_x, clip_y, clip_z;
    logic               w_neg, w_zero;
    div_side_t          side_in;
    logic [NUM_W-1:0]   num_x_reg, num_y_reg, num_z_reg;
    logic [DEN_W-1:0]   den_reg;
    div_side_t          side_reg [NUM_W+1];

    always_comb begin
        clip_x = sat32(49'($signed(p_xs_reg[63:16])) + 49'($signed(p_zox_reg[63:16])));
        clip_y = sat32(49'($signed(p_ys_reg[63:16])) + 49'($signed(p_zoy_reg[63:16])));
        clip_z = sat32(49'($signed(p_zd_reg[63:16])) + 49'($signed(depth_offset_reg)));
        w_zero = (s1_z_reg == 32'sd0);
        w_neg  = !s1_z_reg[31] && !w_zero;
        side_in.valid  = s1_valid_reg;
        side_in.w_zero = w_zero;
        side_in.neg_x  = clip_x[31] ^ w_neg;
        side_in.neg_y  = clip_y[31] ^ w_neg;
        side_in.neg_z  = clip_z[31] ^ w_neg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_x_reg <= {abs32(clip_x), 16'd0};
            num_y_reg <= {abs32(clip_y), 16'd0};
            num_z_reg <= {abs32(clip_z), 16'd0};
            den_reg   <= abs32(s1_z_reg);
        end
    end

    // Carry the control bits alongside the divider stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= NUM_W; i++) begin
                side_reg[i] <= '0;
            end
        end else if (en) begin
            side_reg[0] <= side_in;
            for (int i = 1; i <= NUM_W; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ---------------- divider stages ----------------
    logic [NUM_W-1:0] mag_x, mag_y, mag_z;

    pvp_div u_div_x (.aclk(aclk), .en(en), .num_in(num_x_reg), .den_in(den_reg),
                     .quo_out(mag_x));
    pvp_div u_div_y (.aclk(aclk), .en(en), .num_in(num_y_reg), .den_in(den_reg),
                     .quo_out(mag_y));
    pvp_div u_div_z (.aclk(aclk), .en(en), .num_in(num_z_reg), .den_in(den_reg),
                     .quo_out(mag_z));

    // ---------------- output stage: clip, saturate, raster ----------------
    div_side_t          side_out;
    logic               vis;
    logic signed [31:0] ndc_z;
    logic signed [33:0] ndc_x_s, ndc_y_s, twice_x, twice_y;
    logic [33+XW:0]     prod_x, pix_x_full;
    logic [33+YW:0]     prod_y, pix_y_full;
    logic [PIX_W-1:0]   pix_x, pix_y;
    logic [PIX_W-1:0]   pix_x_reg, pix_y_reg;
    logic signed [31:0] ndc_z_reg;
    logic               vis_reg;

    assign side_out = side_reg[NUM_W];

    always_comb begin
        vis = !side_out.w_zero
              && (mag_x <= {{(NUM_W-31){1'b0}}, clip_x_limit_reg})
              && (mag_y <= Q_ONE_MAG);

        // Saturate the depth quotient
        if (side_out.w_zero) begin
            ndc_z = 32'sd0;
        end else if (side_out.neg_z) begin
            ndc_z = (mag_z > NUM_W'(64'h8000_0000)) ? 32'sh8000_0000
                                                     : 32'sd0 - mag_z[31:0];
        end else begin
            ndc_z = (mag_z > NUM_W'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : mag_z[31:0];
        end

        // Signed quotients; only meaningful when visible
        ndc_x_s = side_out.neg_x ? -$signed({1'b0, mag_x[32:0]})
                                 : $signed({1'b0, mag_x[32:0]});
        ndc_y_s = side_out.neg_y ? -$signed({1'b0, mag_y[32:0]})
                                 : $signed({1'b0, mag_y[32:0]});
        twice_x = ndc_x_s + 34'sd65536;
        twice_y = 34'sd65536 - ndc_y_s;

        // Column
        prod_x     = (34+XW)'(twice_x[32:0]) * (34+XW)'(SIZE_X);
        pix_x_full = prod_x >> 17;
        if (twice_x <= 34'sd0) begin
            pix_x = '0;
        end else if (pix_x_full > (34+XW)'(SIZE_X - 1'b1)) begin
            pix_x = PIX_W'(SIZE_X - 1'b1);
        end else begin
            pix_x = pix_x_full[PIX_W-1:0];
        end

        // Row, top is zero
        prod_y     = (34+YW)'(twice_y[32:0]) * (34+YW)'(SIZE_Y);
        pix_y_full = prod_y >> 17;
        if (twice_y <= 34'sd0) begin
            pix_y = '0;
        end else if (pix_y_full > (34+YW)'(SIZE_Y - 1'b1)) begin
            pix_y = PIX_W'(SIZE_Y - 1'b1);
        end else begin
            pix_y = pix_y_full[PIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= side_out.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vis_reg   <= vis;
            pix_x_reg <= vis ? pix_x : '0;
            pix_y_reg <= vis ? pix_y : '0;
            ndc_z_reg <= ndc_z;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {6'd0, ndc_z_reg, pix_y_reg, pix_x_reg};
    assign m_axis_tuser[0] = vis_reg;

endmodule

`default_nettype wire
